// ===== rtl/masm_pkg.sv =====
// Shared types, codes and constants for the matrix add/subtract/multiply unit.
package masm_pkg;

   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int ELEM_WIDTH_DEFAULT = 16;
   localparam int DIM_WIDTH          = 4;
   localparam int OP_WIDTH           = 2;
   localparam int CMD_WIDTH          = 2;
   localparam int IDX_WIDTH          = 3;
   localparam int IN_WIDTH           = 16;
   localparam int RESULT_WIDTH       = 32;
   localparam int CSR_ADDR_WIDTH     = 5;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic [DIM_WIDTH-1:0] DIM_RESET = 4'd8;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_START   = 2'd2
   } command_type;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2
   } operation_type;

   typedef enum logic [2:0] {
      REG_ROWS_A    = 3'd0,
      REG_COLS_A    = 3'd1,
      REG_ROWS_B    = 3'd2,
      REG_COLS_B    = 3'd3,
      REG_OPERATION = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ISSUE = 2'd1,
      ST_DRAIN = 2'd2,
      ST_EMIT  = 2'd3
   } state_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]       command;
      logic [IDX_WIDTH-1:0]       row_index;
      logic [IDX_WIDTH-1:0]       col_index;
      logic signed [IN_WIDTH-1:0] element_value;
   } req_data_type;

   typedef struct packed {
      logic [IDX_WIDTH-1:0]           out_row;
      logic [IDX_WIDTH-1:0]           out_col;
      logic signed [RESULT_WIDTH-1:0] out_value;
      logic                           last;
      logic                           size_mismatch;
   } rsp_data_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0] rows_a;
      logic [DIM_WIDTH-1:0] cols_a;
      logic [DIM_WIDTH-1:0] rows_b;
      logic [DIM_WIDTH-1:0] cols_b;
      logic [OP_WIDTH-1:0]  operation;
   } cfg_type;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic issue;
      logic acc_clr;
      logic load_out;
      logic last;
      logic mismatch;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/masm_regs.sv =====
// Configuration register file on the APB-style port.
module masm_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [masm_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [masm_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [masm_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready,
   output masm_pkg::cfg_type                    cfg
);
   import masm_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_ROWS_A:    cfg_in.rows_a    = pwdata[DIM_WIDTH-1:0];
            REG_COLS_A:    cfg_in.cols_a    = pwdata[DIM_WIDTH-1:0];
            REG_ROWS_B:    cfg_in.rows_b    = pwdata[DIM_WIDTH-1:0];
            REG_COLS_B:    cfg_in.cols_b    = pwdata[DIM_WIDTH-1:0];
            REG_OPERATION: cfg_in.operation = pwdata[OP_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         REG_ROWS_A:    prdata = CSR_DATA_WIDTH'(cfg_ff.rows_a);
         REG_COLS_A:    prdata = CSR_DATA_WIDTH'(cfg_ff.cols_a);
         REG_ROWS_B:    prdata = CSR_DATA_WIDTH'(cfg_ff.rows_b);
         REG_COLS_B:    prdata = CSR_DATA_WIDTH'(cfg_ff.cols_b);
         REG_OPERATION: prdata = CSR_DATA_WIDTH'(cfg_ff.operation);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_a    <= DIM_RESET;
         cfg_ff.cols_a    <= DIM_RESET;
         cfg_ff.rows_b    <= DIM_RESET;
         cfg_ff.cols_b    <= DIM_RESET;
         cfg_ff.operation <= OP_ADD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/masm_ctrl.sv =====
// Sequencer: walks result elements and the inner product index, drives the datapath.
module masm_ctrl #(
   parameter int  MAX_DIM = masm_pkg::MAX_DIM_DEFAULT,
   localparam int IW      = $clog2(MAX_DIM)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  masm_pkg::cfg_type               cfg,
   input  logic                            req_valid,
   input  logic [masm_pkg::CMD_WIDTH-1:0]  req_command,
   output logic                            req_stall,
   input  masm_pkg::status_type            status,
   output masm_pkg::cmd_type               cmd,
   output logic [IW-1:0]                   row_idx,
   output logic [IW-1:0]                   col_idx,
   output logic [IW-1:0]                   k_idx
);
   import masm_pkg::*;

   localparam int DW = $clog2(MAX_DIM + 1);

   state_type     state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DW-1:0] ra, ca, rb, cb, orows, ocols, n_inner;
   logic          is_mul, op_valid, start_acc, go;
   logic          i_last, j_last, k_last, elem_last, mismatch;

   function automatic logic [DW-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] d);
      if (int'(d) > MAX_DIM) begin
         return DW'(MAX_DIM);
      end
      return DW'(d);
   endfunction

   always_comb begin
      ra        = clamp_dim(cfg.rows_a);
      ca        = clamp_dim(cfg.cols_a);
      rb        = clamp_dim(cfg.rows_b);
      cb        = clamp_dim(cfg.cols_b);
      is_mul    = (cfg.operation == OP_MUL);
      op_valid  = (cfg.operation == OP_ADD) || (cfg.operation == OP_SUB) || is_mul;
      orows     = ra;
      ocols     = is_mul ? cb : ca;
      n_inner   = is_mul ? ca : DW'(1);
      mismatch  = is_mul ? (ca != rb) : ((ra != rb) || (ca != cb));
      i_last    = (DW'(i_ff) + DW'(1)) == orows;
      j_last    = (DW'(j_ff) + DW'(1)) == ocols;
      k_last    = (DW'(k_ff) + DW'(1)) == n_inner;
      elem_last = i_last && j_last;
      start_acc = (state_ff == ST_IDLE) && req_valid && (req_command == CMD_START);
      go        = op_valid && (orows != '0) && (ocols != '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_acc && go) begin
               state_in = (n_inner == '0) ? ST_DRAIN : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = (n_inner == '0) ? ST_DRAIN : ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and loop counters
   always_comb begin
      cmd          = '0;
      cmd.last     = elem_last;
      cmd.mismatch = mismatch;
      req_stall    = (state_ff != ST_IDLE);
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  CMD_WRITE_A: cmd.wr_a = 1'b1;
                  CMD_WRITE_B: cmd.wr_b = 1'b1;
                  default:     cmd.wr_a = 1'b0;
               endcase
            end
            if (start_acc && go) begin
               cmd.acc_clr = 1'b1;
               i_in        = '0;
               j_in        = '0;
               k_in        = '0;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            k_in      = k_last ? '0 : k_ff + IW'(1);
         end
         ST_DRAIN: begin
            k_in = '0;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.acc_clr  = 1'b1;
               k_in         = '0;
               if (j_last) begin
                  j_in = '0;
                  i_in = i_ff + IW'(1);
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end
         end
         default: cmd = '0;
      endcase
   end

   assign row_idx = i_ff;
   assign col_idx = j_ff;
   assign k_idx   = k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

// ===== rtl/masm_dp.sv =====
// Datapath: element stores, multiply-accumulate pipeline and result register.
module masm_dp #(
   parameter int  MAX_DIM    = masm_pkg::MAX_DIM_DEFAULT,
   parameter int  ELEM_WIDTH = masm_pkg::ELEM_WIDTH_DEFAULT,
   localparam int IW         = $clog2(MAX_DIM)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [masm_pkg::OP_WIDTH-1:0]  operation,
   input  masm_pkg::req_data_type         req_data,
   input  masm_pkg::cmd_type              cmd,
   input  logic [IW-1:0]                  row_idx,
   input  logic [IW-1:0]                  col_idx,
   input  logic [IW-1:0]                  k_idx,
   output masm_pkg::status_type           status,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output masm_pkg::rsp_data_type         rsp_data
);
   import masm_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   logic signed [ELEM_WIDTH-1:0]   mem_a_ff [DEPTH];
   logic signed [ELEM_WIDTH-1:0]   mem_b_ff [DEPTH];
   logic [DEPTH-1:0]               valid_a_ff, valid_b_ff;
   logic [AW-1:0]                  wr_addr, rd_addr_a, rd_addr_b;
   logic [IW-1:0]                  a_col, b_row;
   logic                           is_mul, wr_in_range, wr_a, wr_b;
   logic signed [ELEM_WIDTH-1:0]   wr_val;
   logic signed [ELEM_WIDTH-1:0]   rd_a_ff, rd_b_ff;
   logic                           rd_va_ff, rd_vb_ff;
   logic signed [RESULT_WIDTH-1:0] a_val, b_val;
   logic [RESULT_WIDTH-1:0]        term_in, term_ff, acc_in, acc_ff;
   logic                           v1_ff, v2_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_data_type                   rsp_data_ff, rsp_data_in;

   // element writes; drop those outside the store
   assign wr_in_range = (int'(req_data.row_index) < MAX_DIM) &&
                        (int'(req_data.col_index) < MAX_DIM);
   assign wr_a    = cmd.wr_a && wr_in_range;
   assign wr_b    = cmd.wr_b && wr_in_range;
   assign wr_val  = ELEM_WIDTH'($signed(req_data.element_value));
   assign wr_addr = AW'(AW'(req_data.row_index) * AW'(MAX_DIM) + AW'(req_data.col_index));

   // add/sub read both stores at (i,j); multiply walks A(i,k) and B(k,j)
   assign is_mul    = (operation == OP_MUL);
   assign a_col     = is_mul ? k_idx : col_idx;
   assign b_row     = is_mul ? k_idx : row_idx;
   assign rd_addr_a = AW'(AW'(row_idx) * AW'(MAX_DIM) + AW'(a_col));
   assign rd_addr_b = AW'(AW'(b_row) * AW'(MAX_DIM) + AW'(col_idx));

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a_ff[wr_addr] <= wr_val;
      end
      if (wr_b) begin
         mem_b_ff[wr_addr] <= wr_val;
      end
      rd_a_ff  <= mem_a_ff[rd_addr_a];
      rd_b_ff  <= mem_b_ff[rd_addr_b];
      rd_va_ff <= valid_a_ff[rd_addr_a];
      rd_vb_ff <= valid_b_ff[rd_addr_b];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= '0;
         valid_b_ff <= '0;
      end else begin
         if (wr_a) begin
            valid_a_ff[wr_addr] <= 1'b1;
         end
         if (wr_b) begin
            valid_b_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_comb begin
      a_val = rd_va_ff ? RESULT_WIDTH'($signed(rd_a_ff)) : '0;
      b_val = rd_vb_ff ? RESULT_WIDTH'($signed(rd_b_ff)) : '0;
      case (operation)
         OP_ADD:  term_in = a_val + b_val;
         OP_SUB:  term_in = a_val - b_val;
         OP_MUL:  term_in = a_val * b_val;
         default: term_in = '0;
      endcase
   end

   always_comb begin
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + term_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      rsp_data_in.out_row       = IDX_WIDTH'(row_idx);
      rsp_data_in.out_col       = IDX_WIDTH'(col_idx);
      rsp_data_in.out_value     = $signed(acc_ff);
      rsp_data_in.last          = cmd.last;
      rsp_data_in.size_mismatch = cmd.mismatch;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      acc_ff  <= acc_in;
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

// ===== rtl/matrix_add_sub_multiply_unit.sv =====
// Top level of the matrix add/subtract/multiply unit.
//
//   channel  direction  handshake                        word
//   req      in         req_valid / req_stall            req_data_type
//   rsp      out        rsp_valid / rsp_stall            rsp_data_type
//   csr      in/out     psel penable pwrite / pready     32-bit register
//
// An element write is taken while the unit is idle. A start emits rows x cols words,
// each the sum of n terms, with n = cols_a for multiply and 1 for add or subtract (a
// multiply with cols_a of 0 issues no reads): one read of each store per cycle feeds
// a single multiply-accumulate pipeline.
// Per-entry valid bits make unwritten elements read as zero.
// The result register frees the input side once the last word is loaded; a stall
// on rsp holds the sequencer only when the next word is ready to load.
module matrix_add_sub_multiply_unit #(
   parameter int MAX_DIM    = masm_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = masm_pkg::ELEM_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  masm_pkg::req_data_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output masm_pkg::rsp_data_type               rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [masm_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [masm_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [masm_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);
   import masm_pkg::*;

   localparam int IW = $clog2(MAX_DIM);

   cfg_type       cfg;
   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] row_idx, col_idx, k_idx;

   masm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   masm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd),
      .row_idx     (row_idx),
      .col_idx     (col_idx),
      .k_idx       (k_idx)
   );

   masm_dp #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .operation (cfg.operation),
      .req_data  (req_data),
      .cmd       (cmd),
      .row_idx   (row_idx),
      .col_idx   (col_idx),
      .k_idx     (k_idx),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/masm_checker.sv =====
// Port-level checks for the matrix add/subtract/multiply unit, bound to the top level.
module masm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input masm_pkg::req_data_type  req_data,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input masm_pkg::rsp_data_type  rsp_data
);
   import masm_pkg::*;

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // only a start word makes the block busy
   a_busy_on_start: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall && req_data.command == CMD_START))
      else $error("input stalled without an accepted start");

   // the matrix is still being worked while a word before the last is shown
   a_busy_mid_matrix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("input taken before the result matrix finished");

endmodule

bind matrix_add_sub_multiply_unit masm_checker u_masm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/matrix_add_sub_multiply_unit_tb.sv =====
// Self-checking testbench for the matrix add/subtract/multiply unit.
`timescale 1ns / 100ps

module matrix_add_sub_multiply_unit_tb;
   import masm_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 330;
   localparam int DIM_MAX       = 8;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
   localparam logic [OP_WIDTH-1:0]  OP_NONE    = 2'd3;

   // Holds a private copy of both stores and the registers, and the result
   // elements still owed by the block.
   class matrix_scoreboard;
      logic signed [IN_WIDTH-1:0] store_a [DIM_MAX*DIM_MAX];
      logic signed [IN_WIDTH-1:0] store_b [DIM_MAX*DIM_MAX];
      logic [DIM_WIDTH-1:0]       rows_a, cols_a, rows_b, cols_b;
      logic [OP_WIDTH-1:0]        op;
      rsp_data_type               owed_elements [$];
      int                         errors;

      function new();
         foreach (store_a[n]) begin
            store_a[n] = '0;
            store_b[n] = '0;
         end
         rows_a = DIM_RESET;
         cols_a = DIM_RESET;
         rows_b = DIM_RESET;
         cols_b = DIM_RESET;
         op     = OP_ADD;
         errors = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [CSR_DATA_WIDTH-1:0] v);
         case (idx)
            REG_ROWS_A:    rows_a = v[DIM_WIDTH-1:0];
            REG_COLS_A:    cols_a = v[DIM_WIDTH-1:0];
            REG_ROWS_B:    rows_b = v[DIM_WIDTH-1:0];
            REG_COLS_B:    cols_b = v[DIM_WIDTH-1:0];
            REG_OPERATION: op     = v[OP_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int clamp_dim(logic [DIM_WIDTH-1:0] d);
         return (d > DIM_MAX) ? DIM_MAX : int'(d);
      endfunction

      function void compute_matrix();
         int           ra, ca, rb, cb, ocols, acc;
         logic         mism;
         rsp_data_type e;
         ra = clamp_dim(rows_a);
         ca = clamp_dim(cols_a);
         rb = clamp_dim(rows_b);
         cb = clamp_dim(cols_b);
         if (op == OP_MUL) begin
            ocols = cb;
            mism  = (ca != rb);
         end else begin
            ocols = ca;
            mism  = (ra != rb) || (ca != cb);
         end
         for (int i = 0; i < ra; i++) begin
            for (int j = 0; j < ocols; j++) begin
               acc = 0;
               if (op == OP_ADD)
                  acc = store_a[i*DIM_MAX+j] + store_b[i*DIM_MAX+j];
               else if (op == OP_SUB)
                  acc = store_a[i*DIM_MAX+j] - store_b[i*DIM_MAX+j];
               else
                  for (int k = 0; k < ca; k++)
                     acc += store_a[i*DIM_MAX+k] * store_b[k*DIM_MAX+j];
               e.out_row       = i[IDX_WIDTH-1:0];
               e.out_col       = j[IDX_WIDTH-1:0];
               e.out_value     = acc;
               e.last          = (i == ra - 1) && (j == ocols - 1);
               e.size_mismatch = mism;
               owed_elements.push_back(e);
            end
         end
      endfunction

      function void note_word(req_data_type w);
         case (w.command)
            CMD_WRITE_A: store_a[{w.row_index, w.col_index}] = w.element_value;
            CMD_WRITE_B: store_b[{w.row_index, w.col_index}] = w.element_value;
            CMD_START:   if (op != OP_NONE) compute_matrix();
            default: ;
         endcase
      endfunction

      function void flag(string field, longint want, longint got);
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         errors++;
      endfunction

      function void check_element(rsp_data_type got);
         rsp_data_type want;
         if (owed_elements.size() == 0) begin
            $display("%0t: result word with nothing expected, row %0d col %0d value %0d",
                     $time, got.out_row, got.out_col, got.out_value);
            errors++;
            return;
         end
         want = owed_elements.pop_front();
         if (got.out_row !== want.out_row) flag("out_row", want.out_row, got.out_row);
         if (got.out_col !== want.out_col) flag("out_col", want.out_col, got.out_col);
         if (got.out_value !== want.out_value)
            flag("out_value", want.out_value, got.out_value);
         if (got.last !== want.last) flag("last", want.last, got.last);
         if (got.size_mismatch !== want.size_mismatch)
            flag("size_mismatch", want.size_mismatch, got.size_mismatch);
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   req_data_type                  req_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   rsp_data_type                  rsp_data;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [CSR_ADDR_WIDTH-1:0]     paddr;
   logic [CSR_DATA_WIDTH-1:0]     pwdata;
   logic [CSR_DATA_WIDTH-1:0]     prdata;
   logic                          pready;

   matrix_scoreboard board;
   bit               tx_quiet;
   bit               rx_quiet;
   int               cycle_count;

   matrix_add_sub_multiply_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Valid is only lowered when a gap follows, so it never drops and rises in one step.
   task automatic send(input logic [CMD_WIDTH-1:0] cmd, input int row, input int col,
                       input logic [IN_WIDTH-1:0] value);
      req_data_type w;
      int           gap;
      w.command       = cmd;
      w.row_index     = row[IDX_WIDTH-1:0];
      w.col_index     = col[IDX_WIDTH-1:0];
      w.element_value = value;
      gap = tx_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.note_word(w);
   endtask

   // Leave psel high between writes; a fresh setup cycle follows each access.
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_WIDTH-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      board.set_reg(idx, v);
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] with_junk(logic [3:0] low);
      logic [CSR_DATA_WIDTH-1:0] v;
      v      = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      v[3:0] = low;
      return v;
   endfunction

   task automatic load_config(input logic [3:0] ra, input logic [3:0] ca,
                              input logic [3:0] rb, input logic [3:0] cb,
                              input logic [OP_WIDTH-1:0] op);
      // drop the last accepted word so it is not taken again
      req_valid <= 1'b0;
      write_reg(REG_ROWS_A, with_junk(ra));
      write_reg(REG_COLS_A, with_junk(ca));
      write_reg(REG_ROWS_B, with_junk(rb));
      write_reg(REG_COLS_B, with_junk(cb));
      write_reg(REG_OPERATION, with_junk({2'($urandom_range(0, 3)), op}));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Wait until every owed element is back, then give a silent start time to finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.owed_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [3:0] draw_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 4'd0;
      if (r < 10) return 4'($urandom_range(9, 15));
      if (r < 18) return 4'd8;
      return 4'($urandom_range(1, 4));
   endfunction

   function automatic int span(logic [3:0] d);
      return (d == 0) ? 1 : (d > DIM_MAX) ? DIM_MAX : int'(d);
   endfunction

   function automatic logic [IN_WIDTH-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Accept a result word at every edge where valid is high and stall is low.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = rx_quiet ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         board.check_element(rsp_data);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("matrix_add_sub_multiply_unit regression: fail");
      $finish;
   end

   initial begin
      logic [3:0]          ra, ca, rb, cb;
      logic [OP_WIDTH-1:0] op;
      int                  random_count;
      int                  rr, cc;
      board     = new();
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      tx_quiet  = 1'b0;
      rx_quiet  = 1'b0;
      random_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner elements, extremes, an unused command, then add on the reset shape.
      send(CMD_WRITE_A, 0, 0, 16'h7fff);
      send(CMD_WRITE_A, 7, 7, 16'h8000);
      send(CMD_WRITE_B, 0, 0, 16'h7fff);
      send(CMD_WRITE_B, 7, 7, 16'h8000);
      send(CMD_WRITE_A, 0, 7, 16'hffff);
      send(CMD_WRITE_B, 7, 0, 16'h5555);
      send(CMD_UNUSED, 5, 2, 16'h1234);
      send(CMD_START, 0, 0, 16'h0000);
      settle();
      load_config(4'd8, 4'd8, 4'd8, 4'd8, OP_SUB);
      send(CMD_START, 7, 7, 16'hffff);
      settle();
      // Two products of the most negative value push the sum past the signed range.
      send(CMD_WRITE_A, 0, 1, 16'h8000);
      send(CMD_WRITE_B, 1, 0, 16'h8000);
      send(CMD_WRITE_A, 0, 2, 16'h8000);
      send(CMD_WRITE_B, 2, 0, 16'h8000);
      load_config(4'd8, 4'd8, 4'd8, 4'd8, OP_MUL);
      send(CMD_START, 0, 0, 16'h0000);
      settle();
      load_config(4'd8, 4'd8, 4'd8, 4'd8, OP_NONE);
      send(CMD_START, 0, 0, 16'h0000);
      settle();
      load_config(4'd0, 4'd8, 4'd8, 4'd8, OP_ADD);
      send(CMD_START, 0, 0, 16'h0000);
      settle();
      load_config(4'd15, 4'd3, 4'd2, 4'd12, OP_MUL);
      send(CMD_START, 0, 0, 16'h0000);
      settle();
      load_config(4'd15, 4'd3, 4'd2, 4'd12, OP_ADD);
      send(CMD_START, 0, 0, 16'h0000);
      settle();
      load_config(4'd2, 4'd3, 4'd3, 4'd2, OP_MUL);
      send(CMD_START, 0, 0, 16'h0000);
      settle();

      // Random phases: mostly loads inside the shapes in use followed by a start.
      while (random_count < RANDOM_ITEMS) begin
         ra = draw_dim();
         ca = draw_dim();
         op = ($urandom_range(0, 19) == 0) ? OP_NONE : OP_WIDTH'($urandom_range(0, 2));
         if ($urandom_range(0, 9) < 6) begin
            if (op == OP_MUL) begin
               rb = ca;
               cb = draw_dim();
            end else begin
               rb = ra;
               cb = ca;
            end
         end else begin
            rb = draw_dim();
            cb = draw_dim();
         end
         load_config(ra, ca, rb, cb, op);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 12)) begin
               rr = $urandom_range(0, 7);
               cc = $urandom_range(0, 7);
               case ($urandom_range(0, 13))
                  0: send(CMD_UNUSED, rr, cc, draw_value());
                  1: begin
                     send(CMD_WRITE_A, rr, cc, draw_value());
                     random_count++;
                  end
                  2: begin
                     send(CMD_WRITE_B, rr, cc, draw_value());
                     random_count++;
                  end
                  3, 4, 5, 6, 7: begin
                     send(CMD_WRITE_A, $urandom_range(0, span(ra) - 1),
                          $urandom_range(0, span(ca) - 1), draw_value());
                     random_count++;
                  end
                  default: begin
                     send(CMD_WRITE_B, $urandom_range(0, span(rb) - 1),
                          $urandom_range(0, span(cb) - 1), draw_value());
                     random_count++;
                  end
               endcase
            end
            if ($urandom_range(0, 9) != 0) begin
               send(CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), draw_value());
               random_count++;
            end
         end
         settle();
      end

      if (board.errors == 0 && board.owed_elements.size() == 0)
         $display("matrix_add_sub_multiply_unit regression: pass");
      else
         $display("matrix_add_sub_multiply_unit regression: fail");
      $finish;
   end

endmodule
